// File: hdl/xyse_pkg.sv
// Shared types, constants and functions for the XY lattice site energy block.
// Holds the controller state enum, the command enum, the evaluator control struct,
// the table-based Q.14 sine and the coordinate wrap. No dependencies.
package xyse_pkg;

    localparam int XYSE_SIDE  = 16;
    localparam int ANGLE_W    = 16;
    localparam int COORD_IN_W = 4;
    localparam int TRIG_W     = 16;
    localparam int ENERGY_W   = 18;
    localparam int SUM_W      = 17;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WAIT,
        S_DONE
    } t_state;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    // Control that travels with one neighbor through the evaluator.
    typedef struct packed {
        logic       valid;
        logic       upper;  // neighbor on the upper side of its axis
        logic [1:0] axis;
        logic       last;   // final neighbor of the query
    } t_eval_ctl;

    // round(16384*sin(k*pi/64)) for k = 0..32.
    function automatic logic [14:0] quarter_sine(input logic [5:0] k);
        logic [14:0] v;
        case (k)
            6'd0:  v = 15'd0;
            6'd1:  v = 15'd804;
            6'd2:  v = 15'd1606;
            6'd3:  v = 15'd2404;
            6'd4:  v = 15'd3196;
            6'd5:  v = 15'd3981;
            6'd6:  v = 15'd4756;
            6'd7:  v = 15'd5520;
            6'd8:  v = 15'd6270;
            6'd9:  v = 15'd7005;
            6'd10: v = 15'd7723;
            6'd11: v = 15'd8423;
            6'd12: v = 15'd9102;
            6'd13: v = 15'd9760;
            6'd14: v = 15'd10394;
            6'd15: v = 15'd11003;
            6'd16: v = 15'd11585;
            6'd17: v = 15'd12140;
            6'd18: v = 15'd12665;
            6'd19: v = 15'd13160;
            6'd20: v = 15'd13623;
            6'd21: v = 15'd14053;
            6'd22: v = 15'd14449;
            6'd23: v = 15'd14811;
            6'd24: v = 15'd15137;
            6'd25: v = 15'd15426;
            6'd26: v = 15'd15679;
            6'd27: v = 15'd15893;
            6'd28: v = 15'd16069;
            6'd29: v = 15'd16207;
            6'd30: v = 15'd16305;
            6'd31: v = 15'd16364;
            6'd32: v = 15'd16384;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Sine of a turn fraction in Q.14, by quadrant folding and linear
    // interpolation between 33 table points.
    function automatic logic signed [TRIG_W-1:0] sine_q14(input logic [ANGLE_W-1:0] a);
        logic [14:0] m;
        logic [5:0]  idx;
        logic [8:0]  frac;
        logic [14:0] t0;
        logic [14:0] t1;
        logic [9:0]  d;
        logic [18:0] prod;
        logic [14:0] v;
        m = {1'b0, a[13:0]};
        if (a[14]) begin
            m = 15'd16384 - m;
        end
        idx  = m[14:9];
        frac = m[8:0];
        t0   = quarter_sine(idx);
        t1   = quarter_sine(idx + 6'd1);
        d    = 10'(t1 - t0);
        prod = 19'({9'b0, d} * {10'b0, frac}) + 19'd256;
        if (idx >= 6'd32) begin
            v = 15'd16384;
        end else begin
            v = t0 + 15'(prod >> 9);
        end
        return a[15] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // Coordinate modulo side by repeated subtraction; a 4-bit value needs at
    // most seven steps for the smallest side.
    function automatic logic [COORD_IN_W-1:0] wrap_coord(input logic [COORD_IN_W-1:0] v,
                                                         input int side);
        logic [COORD_IN_W:0] acc;
        acc = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (int'(acc) >= side) begin
                acc = acc - (COORD_IN_W+1)'(side);
            end
        end
        return acc[COORD_IN_W-1:0];
    endfunction

endpackage

// File: hdl/xyse_lattice_ram.sv
// Lattice angle memory: one write port, one read port, registered read data.
// Depends on nothing; sized by the top level.
module xyse_lattice_ram #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/xyse_nb_eval.sv
// Neighbor evaluator: cosine of the site difference and the axis sine term
// for one neighbor, registered. Uses xyse_pkg for the sine table and types.
module xyse_nb_eval (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [xyse_pkg::ANGLE_W-1:0]    i_center,
    input  logic [xyse_pkg::ANGLE_W-1:0]    i_nb,
    input  logic [xyse_pkg::ANGLE_W-1:0]    i_trial,
    input  xyse_pkg::t_eval_ctl             i_ctl,
    output xyse_pkg::t_eval_ctl             o_ctl,
    output logic signed [xyse_pkg::TRIG_W-1:0] o_cos,
    output logic signed [xyse_pkg::TRIG_W-1:0] o_sin
);
    import xyse_pkg::*;

    logic [ANGLE_W-1:0]       cos_arg;
    logic [ANGLE_W-1:0]       sin_arg;
    t_eval_ctl                r_ctl;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;

    // Cosine is the sine a quarter turn ahead.
    assign cos_arg = i_center - i_nb + 16'h4000;
    assign sin_arg = i_ctl.upper ? (i_trial - i_nb) : (i_nb - i_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos <= sine_q14(cos_arg);
        r_sin <= sine_q14(sin_arg);
    end

    assign o_ctl = r_ctl;
    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

// File: hdl/xy_lattice_site_energy.sv
// Top level of the XY lattice site energy block: controller, address
// generation, accumulation and output register. Uses xyse_pkg,
// xyse_lattice_ram and xyse_nb_eval.
//
//  Channel  | Direction | Beat contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: x, y, z, angle (write/trial)
//  m_axis   | out       | tdata: site_energy, sine_sum_x, sine_sum_y, sine_sum_z
//
// A write beat puts its angle into the lattice memory at the accepting edge. A
// query beat makes seven reads of the single read port (site, then lower and
// upper neighbors along x, y, z); the memory registers each read, the evaluator
// registers each neighbor term for the accumulators, and the finished sums are
// loaded into the output register. After reset the memory is cleared, one
// entry a cycle through all SIDE^3 entries (4096 at the default side), and
// s_axis_tready stays low until the clearing pass has reached the last entry.
// A finished result waits in the output register, and a new beat is taken
// while it waits; only the load of the next result stalls on m_axis_tready.
module xy_lattice_site_energy #(
    parameter int SIDE = xyse_pkg::XYSE_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] coord_x, [7:4] coord_y, [11:8] coord_z, [27:12] angle_value,
    // [31:28] zero
    input  logic [31:0] i_s_axis_tdata,
    // [0] command
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [17:0] site_energy, [34:18] sine_sum_x, [51:35] sine_sum_y,
    // [68:52] sine_sum_z, [71:69] zero
    output logic [71:0] o_m_axis_tdata
);
    import xyse_pkg::*;

    localparam int CELLS = SIDE * SIDE * SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(SIDE);

    localparam logic [AW-1:0] SIDE_A    = AW'(SIDE);
    localparam logic [AW-1:0] SIDE_SQ_A = AW'(SIDE * SIDE);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [CW-1:0] CMAX      = CW'(SIDE - 1);

    // Read order of one query.
    localparam logic [2:0] RD_CENTER = 3'd0;
    localparam logic [2:0] RD_XM     = 3'd1;
    localparam logic [2:0] RD_XP     = 3'd2;
    localparam logic [2:0] RD_YM     = 3'd3;
    localparam logic [2:0] RD_YP     = 3'd4;
    localparam logic [2:0] RD_ZM     = 3'd5;
    localparam logic [2:0] RD_ZP     = 3'd6;

    function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                                input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
        return AW'(x) * SIDE_SQ_A + AW'(y) * SIDE_A + AW'(z);
    endfunction

    t_state                     r_state;
    t_state                     n_state;
    logic [AW-1:0]              r_clr_addr;
    logic [CW-1:0]              r_x;
    logic [CW-1:0]              r_y;
    logic [CW-1:0]              r_z;
    logic [ANGLE_W-1:0]         r_trial;
    logic [2:0]                 r_rd_cnt;
    logic                       r_rd_valid;
    logic [2:0]                 r_rd_idx;
    logic [ANGLE_W-1:0]         r_center;
    logic signed [ENERGY_W-1:0] r_energy;
    logic signed [SUM_W-1:0]    r_sum_x;
    logic signed [SUM_W-1:0]    r_sum_y;
    logic signed [SUM_W-1:0]    r_sum_z;
    logic                       r_out_valid;
    logic [71:0]                r_out_data;

    logic                       in_cmd;
    logic [CW-1:0]              in_x;
    logic [CW-1:0]              in_y;
    logic [CW-1:0]              in_z;
    logic [ANGLE_W-1:0]         in_angle;
    logic                       s_ready;
    logic                       in_fire;
    logic                       out_free;
    logic                       load_out;
    logic                       rd_issue;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [ANGLE_W-1:0]         ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [ANGLE_W-1:0]         ram_rdata;
    logic [CW-1:0]              xm, xp, ym, yp, zm, zp;
    t_eval_ctl                  ev_in;
    t_eval_ctl                  ev_out;
    logic signed [TRIG_W-1:0]   ev_cos;
    logic signed [TRIG_W-1:0]   ev_sin;

    // Input beat fields; coordinates are folded into the lattice.
    assign in_cmd   = i_s_axis_tuser[0];
    assign in_x     = CW'(wrap_coord(i_s_axis_tdata[3:0], SIDE));
    assign in_y     = CW'(wrap_coord(i_s_axis_tdata[7:4], SIDE));
    assign in_z     = CW'(wrap_coord(i_s_axis_tdata[11:8], SIDE));
    assign in_angle = i_s_axis_tdata[27:12];

    assign in_fire  = i_s_axis_tvalid && s_ready;
    assign out_free = !r_out_valid || i_m_axis_tready;

    // Wrap-around neighbor coordinates of the latched site.
    assign xm = (r_x == '0) ? CMAX : r_x - CW'(1);
    assign xp = (r_x == CMAX) ? '0 : r_x + CW'(1);
    assign ym = (r_y == '0) ? CMAX : r_y - CW'(1);
    assign yp = (r_y == CMAX) ? '0 : r_y + CW'(1);
    assign zm = (r_z == '0) ? CMAX : r_z - CW'(1);
    assign zp = (r_z == CMAX) ? '0 : r_z + CW'(1);

    always_comb begin
        case (r_rd_cnt)
            RD_CENTER: ram_raddr = site_addr(r_x, r_y, r_z);
            RD_XM:     ram_raddr = site_addr(xm, r_y, r_z);
            RD_XP:     ram_raddr = site_addr(xp, r_y, r_z);
            RD_YM:     ram_raddr = site_addr(r_x, ym, r_z);
            RD_YP:     ram_raddr = site_addr(r_x, yp, r_z);
            RD_ZM:     ram_raddr = site_addr(r_x, r_y, zm);
            RD_ZP:     ram_raddr = site_addr(r_x, r_y, zp);
            default:   ram_raddr = site_addr(r_x, r_y, r_z);
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_CELL) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire && in_cmd == CMD_QUERY) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_rd_cnt == RD_ZP) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (ev_out.valid && ev_out.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs of each state.
    always_comb begin
        s_ready   = 1'b0;
        rd_issue  = 1'b0;
        load_out  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = site_addr(in_x, in_y, in_z);
        ram_wdata = in_angle;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                ram_we  = i_s_axis_tvalid && in_cmd == CMD_WRITE;
            end
            S_READ: begin
                rd_issue = 1'b1;
            end
            S_WAIT: begin
            end
            S_DONE: begin
                load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_rd_cnt    <= RD_CENTER;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_issue;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (in_fire) begin
                r_rd_cnt <= RD_CENTER;
            end else if (rd_issue) begin
                r_rd_cnt <= r_rd_cnt + 3'd1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Query operands, read tags, accumulators and the result beat.
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_rd_cnt;
        if (in_fire) begin
            r_x     <= in_x;
            r_y     <= in_y;
            r_z     <= in_z;
            r_trial <= in_angle;
        end
        if (r_rd_valid && r_rd_idx == RD_CENTER) begin
            r_center <= ram_rdata;
        end
        if (in_fire) begin
            r_energy <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_z  <= '0;
        end else if (ev_out.valid) begin
            r_energy <= r_energy - ENERGY_W'(ev_cos);
            case (ev_out.axis)
                2'd0:    r_sum_x <= r_sum_x + SUM_W'(ev_sin);
                2'd1:    r_sum_y <= r_sum_y + SUM_W'(ev_sin);
                2'd2:    r_sum_z <= r_sum_z + SUM_W'(ev_sin);
                default: r_sum_x <= r_sum_x;
            endcase
        end
        if (load_out) begin
            r_out_data <= {3'b000, r_sum_z, r_sum_y, r_sum_x, r_energy};
        end
    end

    // Neighbor reads feed the evaluator; the site read only sets the center.
    always_comb begin
        ev_in.valid = r_rd_valid && r_rd_idx != RD_CENTER;
        ev_in.upper = !r_rd_idx[0];
        ev_in.axis  = 2'((r_rd_idx - 3'd1) >> 1);
        ev_in.last  = r_rd_idx == RD_ZP;
    end

    xyse_lattice_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (ANGLE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    xyse_nb_eval u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_center (r_center),
        .i_nb     (ram_rdata),
        .i_trial  (r_trial),
        .i_ctl    (ev_in),
        .o_ctl    (ev_out),
        .o_cos    (ev_cos),
        .o_sin    (ev_sin)
    );

    assign o_s_axis_tready = s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Evaluator results only appear while a query is being read.
    a_eval_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ev_out.valid |-> (r_state == S_READ || r_state == S_WAIT))
        else $error("neighbor result outside a query");

    // The last neighbor hands the query over to the result load.
    a_last_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ev_out.valid && ev_out.last) |=> r_state == S_DONE)
        else $error("last neighbor did not finish the query");

    // A new result beat only follows a finished query.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == S_DONE)
        else $error("result beat without a finished query");

    // Lattice reads stay inside the lattice.
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |-> ram_raddr <= LAST_CELL)
        else $error("lattice read out of range");

endmodule

// File: bench/xy_lattice_site_energy_tb.sv
// Self-checking testbench for xy_lattice_site_energy: streams write and query beats,
// predicts every query result from a private lattice copy and compares field by field.
// Depends on xyse_pkg for the command codes and on the block itself.
module xy_lattice_site_energy_tb;
    import xyse_pkg::*;

    localparam int ITEM_TARGET  = 1850;
    localparam int DRAIN_POINT  = 1000;  // the sender waits for an empty scoreboard here
    localparam int HOLD_AFTER   = 300;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_TAIL   = 200;   // beats left when all idling stops
    localparam int TAIL_CYCLES  = 40;
    // Slowest correct run between two handshakes: the clearing pass after reset,
    // the long hold-off, a stall burst and a query; taken several times.
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        logic [15:0] angle;
        logic        drain_first;  // hold this beat until no result is outstanding
    } t_lattice_beat;

    typedef struct packed {
        logic signed [17:0] energy;
        logic signed [16:0] sum_x;
        logic signed [16:0] sum_y;
        logic signed [16:0] sum_z;
    } t_site_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    // [3:0] coord_x, [7:4] coord_y, [11:8] coord_z, [27:12] angle_value, [31:28] zero
    logic [31:0] i_s_axis_tdata = '0;
    // [0] command
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // [17:0] site_energy, [34:18] sine_sum_x, [51:35] sine_sum_y, [68:52] sine_sum_z
    logic [71:0] o_m_axis_tdata;

    xy_lattice_site_energy dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: a private copy of the lattice and the sine table.
    logic [15:0]   lattice_copy [0:4095];
    int            quarter_wave [0:32] = '{
        0, 804, 1606, 2404, 3196, 3981, 4756, 5520,
        6270, 7005, 7723, 8423, 9102, 9760, 10394, 11003,
        11585, 12140, 12665, 13160, 13623, 14053, 14449, 14811,
        15137, 15426, 15679, 15893, 16069, 16207, 16305, 16364,
        16384
    };

    t_lattice_beat pending_beats [$];
    t_site_result  energy_expected [$];
    t_lattice_beat beat_on_bus;
    logic          drain_next = 1'b0;
    logic          idle_allowed = 1'b0;
    int            sender_gap = 0;
    int            sink_gap = 0;
    int            hold_left = 0;
    logic          hold_done = 1'b0;
    int            beats_accepted = 0;
    int            results_seen = 0;
    int            mismatches = 0;
    int            stall_cycles = 0;
    logic          offer_now;
    logic          ready_now;

    // Sine of a turn fraction in Q.14: fold into the first quadrant, then
    // interpolate linearly between the 33 table points.
    function automatic int turn_sine(input logic [15:0] a);
        int m;
        int idx;
        int frac;
        int v;
        m = int'(a[13:0]);
        if (a[14]) begin
            m = 16384 - m;
        end
        idx  = m >> 9;
        frac = m & 511;
        if (idx >= 32) begin
            v = quarter_wave[32];
        end else begin
            v = quarter_wave[idx]
                + (((quarter_wave[idx+1] - quarter_wave[idx]) * frac + 256) >> 9);
        end
        return a[15] ? -v : v;
    endfunction

    function automatic int turn_cosine(input logic [15:0] a);
        logic [15:0] shifted;
        shifted = a + 16'h4000;
        return turn_sine(shifted);
    endfunction

    function automatic int site_addr(input logic [3:0] x, input logic [3:0] y,
                                     input logic [3:0] z);
        return int'({x, y, z});
    endfunction

    // Writes update the lattice copy; queries read the site and its six
    // wrap-around neighbors and queue the expected energy and sine sums.
    task automatic apply_lattice_beat(input t_lattice_beat b);
        logic [15:0]  center;
        logic [15:0]  nbr [0:5];
        logic [15:0]  diff;
        int           energy;
        t_site_result r;
        if (b.cmd == CMD_WRITE) begin
            lattice_copy[site_addr(b.x, b.y, b.z)] = b.angle;
        end else begin
            center = lattice_copy[site_addr(b.x, b.y, b.z)];
            nbr[0] = lattice_copy[site_addr(b.x - 4'd1, b.y, b.z)];
            nbr[1] = lattice_copy[site_addr(b.x + 4'd1, b.y, b.z)];
            nbr[2] = lattice_copy[site_addr(b.x, b.y - 4'd1, b.z)];
            nbr[3] = lattice_copy[site_addr(b.x, b.y + 4'd1, b.z)];
            nbr[4] = lattice_copy[site_addr(b.x, b.y, b.z - 4'd1)];
            nbr[5] = lattice_copy[site_addr(b.x, b.y, b.z + 4'd1)];
            energy = 0;
            for (int i = 0; i < 6; i++) begin
                diff   = center - nbr[i];
                energy = energy - turn_cosine(diff);
            end
            r.energy = 18'(energy);
            r.sum_x  = 17'(turn_sine(16'(nbr[0] - b.angle)) + turn_sine(16'(b.angle - nbr[1])));
            r.sum_y  = 17'(turn_sine(16'(nbr[2] - b.angle)) + turn_sine(16'(b.angle - nbr[3])));
            r.sum_z  = 17'(turn_sine(16'(nbr[4] - b.angle)) + turn_sine(16'(b.angle - nbr[5])));
            energy_expected.push_back(r);
        end
    endtask

    task automatic push_beat(input t_cmd cmd, input logic [3:0] x, input logic [3:0] y,
                             input logic [3:0] z, input logic [15:0] angle);
        t_lattice_beat b;
        b.cmd         = cmd;
        b.x           = x;
        b.y           = y;
        b.z           = z;
        b.angle       = angle;
        b.drain_first = drain_next;
        drain_next    = 1'b0;
        pending_beats.push_back(b);
    endtask

    // Angles lean toward quadrant edges and the ends of the range, where the
    // table folding and the final table entry are exercised.
    function automatic logic [15:0] pick_angle();
        logic [15:0] base;
        case ($urandom_range(0, 7))
            0: begin
                base = 16'({$urandom_range(0, 3), 14'd0});
                return base + 16'($urandom_range(0, 4)) - 16'd2;
            end
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // A well-formed sequence: write a few sites of one neighborhood, then
    // query its center, sometimes twice with independently picked trial angles.
    task automatic push_neighborhood();
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
        logic [3:0] nx;
        logic [3:0] ny;
        logic [3:0] nz;
        int         writes;
        x = 4'($urandom);
        y = 4'($urandom);
        z = 4'($urandom);
        writes = $urandom_range(1, 7);
        for (int k = 0; k < writes; k++) begin
            nx = x;
            ny = y;
            nz = z;
            case ($urandom_range(0, 6))
                1: nx = x - 4'd1;
                2: nx = x + 4'd1;
                3: ny = y - 4'd1;
                4: ny = y + 4'd1;
                5: nz = z - 4'd1;
                6: nz = z + 4'd1;
                default: ;
            endcase
            push_beat(CMD_WRITE, nx, ny, nz, pick_angle());
        end
        push_beat(CMD_QUERY, x, y, z, pick_angle());
        if ($urandom_range(0, 3) == 0) begin
            push_beat(CMD_QUERY, x, y, z, pick_angle());
        end
    endtask

    task automatic push_random_mix(input int target);
        int pick;
        while (pending_beats.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                push_neighborhood();
            end else if (pick < 8) begin
                push_beat(CMD_WRITE, 4'($urandom), 4'($urandom), 4'($urandom), pick_angle());
            end else begin
                push_beat(CMD_QUERY, 4'($urandom), 4'($urandom), 4'($urandom), pick_angle());
            end
        end
    endtask

    // Sender: offers the next pending beat, predicts each accepted one and
    // idles in random bursts while idling is allowed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            foreach (lattice_copy[i]) begin
                lattice_copy[i] = '0;
            end
        end else begin
            offer_now = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_lattice_beat(beat_on_bus);
                beats_accepted++;
                offer_now = 1'b0;
            end
            if (!offer_now) begin
                if (sender_gap > 0) begin
                    sender_gap--;
                end else if (pending_beats.size() > 0 &&
                             (!pending_beats[0].drain_first || energy_expected.size() == 0)) begin
                    if (idle_allowed && $urandom_range(0, 7) == 0) begin
                        sender_gap = $urandom_range(0, 16);
                    end else begin
                        beat_on_bus = pending_beats.pop_front();
                        offer_now   = 1'b1;
                    end
                end
            end
            i_s_axis_tvalid <= offer_now;
            if (offer_now) begin
                i_s_axis_tdata <= {4'b0, beat_on_bus.angle, beat_on_bus.z,
                                   beat_on_bus.y, beat_on_bus.x};
                i_s_axis_tuser <= beat_on_bus.cmd;
            end
            // Every fourth stretch of 150 beats runs without idling, and so
            // does the tail of the run.
            idle_allowed <= pending_beats.size() > QUIET_TAIL &&
                            (beats_accepted / 150) % 4 != 3;
        end
    end

    // Receiver: checks each result beat against the oldest expectation and
    // throttles tready, including one long hold-off that backs up the block.
    always @(posedge i_clk) begin
        t_site_result want;
        t_site_result got;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                got.energy = o_m_axis_tdata[17:0];
                got.sum_x  = o_m_axis_tdata[34:18];
                got.sum_y  = o_m_axis_tdata[51:35];
                got.sum_z  = o_m_axis_tdata[68:52];
                if (energy_expected.size() == 0) begin
                    $error("result beat with no query outstanding: energy %0d", got.energy);
                    mismatches++;
                end else begin
                    want = energy_expected.pop_front();
                    if (got.energy !== want.energy) begin
                        $error("site_energy mismatch: expected %0d, got %0d",
                               want.energy, got.energy);
                        mismatches++;
                    end
                    if (got.sum_x !== want.sum_x) begin
                        $error("sine_sum_x mismatch: expected %0d, got %0d",
                               want.sum_x, got.sum_x);
                        mismatches++;
                    end
                    if (got.sum_y !== want.sum_y) begin
                        $error("sine_sum_y mismatch: expected %0d, got %0d",
                               want.sum_y, got.sum_y);
                        mismatches++;
                    end
                    if (got.sum_z !== want.sum_z) begin
                        $error("sine_sum_z mismatch: expected %0d, got %0d",
                               want.sum_z, got.sum_z);
                        mismatches++;
                    end
                end
            end
            ready_now = 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                ready_now = 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                ready_now = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                ready_now = 1'b0;
            end else if (idle_allowed && $urandom_range(0, 7) == 0) begin
                sink_gap  = $urandom_range(0, 16);
                ready_now = 1'b0;
            end
            i_m_axis_tready <= ready_now;
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("xy_lattice_site_energy_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        // Cold lattice: every cosine is one, every sine sum zero.
        push_beat(CMD_QUERY, 4'd0, 4'd0, 4'd0, 16'h0000);
        push_beat(CMD_QUERY, 4'd15, 4'd15, 4'd15, 16'hFFFF);
        // Extremes of coordinates and angles, with neighbors across the wrap.
        push_beat(CMD_WRITE, 4'd15, 4'd15, 4'd15, 16'hFFFF);
        push_beat(CMD_WRITE, 4'd0, 4'd0, 4'd0, 16'h8000);
        push_beat(CMD_WRITE, 4'd1, 4'd0, 4'd0, 16'h4000);
        push_beat(CMD_WRITE, 4'd15, 4'd0, 4'd0, 16'hC000);
        push_beat(CMD_WRITE, 4'd0, 4'd15, 4'd0, 16'h0001);
        push_beat(CMD_WRITE, 4'd0, 4'd1, 4'd0, 16'h3FFF);
        push_beat(CMD_WRITE, 4'd0, 4'd0, 4'd15, 16'hBFFF);
        push_beat(CMD_WRITE, 4'd0, 4'd0, 4'd1, 16'h7FFF);
        push_beat(CMD_QUERY, 4'd0, 4'd0, 4'd0, 16'h2000);
        push_beat(CMD_QUERY, 4'd0, 4'd0, 4'd0, 16'hFFFF);
        push_beat(CMD_QUERY, 4'd15, 4'd15, 4'd15, 16'h0000);
        push_beat(CMD_QUERY, 4'd1, 4'd0, 4'd0, 16'h4000);
        push_beat(CMD_QUERY, 4'd0, 4'd15, 4'd0, 16'hC001);
        // A query leaves the lattice alone: the same query twice must agree.
        push_beat(CMD_WRITE, 4'd7, 4'd8, 4'd9, 16'h1234);
        push_beat(CMD_WRITE, 4'd8, 4'd8, 4'd9, 16'h5234);
        push_beat(CMD_QUERY, 4'd7, 4'd8, 4'd9, 16'hA5A5);
        push_beat(CMD_QUERY, 4'd7, 4'd8, 4'd9, 16'hA5A5);
        push_beat(CMD_QUERY, 4'd10, 4'd5, 4'd3, 16'h5A5A);
        // Overwrite a site and read it back.
        push_beat(CMD_WRITE, 4'd15, 4'd15, 4'd15, 16'h0000);
        push_beat(CMD_QUERY, 4'd0, 4'd15, 4'd15, 16'h8000);

        push_random_mix(DRAIN_POINT);
        drain_next = 1'b1;
        push_random_mix(ITEM_TARGET);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
        while (energy_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && energy_expected.size() == 0) begin
            $display("xy_lattice_site_energy_tb passed");
        end else begin
            $display("xy_lattice_site_energy_tb failed");
        end
        $finish;
    end

endmodule
